// ----- hw/rtl/mpc_weighted_gram_hessian_top_assert.svh -----
// Assertion macros for the weighted Gram Hessian block.
`ifndef MPC_WEIGHTED_GRAM_HESSIAN_TOP_ASSERT_SVH
`define MPC_WEIGHTED_GRAM_HESSIAN_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MWGH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MWGH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/mwgh_pkg.sv -----
package mwgh_pkg;
	localparam int MAX_ROWS    = 256;
	localparam int MAX_COLS    = 64;
	localparam int MAX_OUTPUTS = 8;
	localparam int MAX_INPUTS  = 8;
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int OUT_W  = $clog2(MAX_OUTPUTS);
	localparam int INP_W  = $clog2(MAX_INPUTS);
	localparam int GADR_W = ROW_W + COL_W;
	localparam int ACC_W  = 128;

	typedef enum logic [1:0] {
		FUNC_LOAD_G = 2'd0,
		FUNC_LOAD_Q = 2'd1,
		FUNC_LOAD_R = 2'd2,
		FUNC_ROW    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_NUM_OUTPUTS  = 2'd0,
		REG_NUM_INPUTS   = 2'd1,
		REG_PRED_HORIZON = 2'd2,
		REG_CTRL_HORIZON = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [3:0] num_outputs;
		logic [3:0] num_inputs;
		logic [5:0] pred_horizon;
		logic [3:0] ctrl_horizon;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  row_index;
		logic [5:0]  col_index;
		logic [31:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  out_row;
		logic [5:0]  out_col;
		logic [63:0] h_value;
		logic        status;
		logic        last;
	} out_item_t;

	function automatic logic [63:0] round_sat(input logic [ACC_W-1:0] a);
		logic [ACC_W-1:0] s;
		logic [ACC_W-17:0] sh;
		logic [63:0] res;
		s  = a + ACC_W'(32'h8000);
		sh = s[ACC_W-1:16];
		if (sh[ACC_W-17:63] == '0 || sh[ACC_W-17:63] == '1) begin
			res = sh[63:0];
		end else begin
			res = s[ACC_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return res;
	endfunction
endpackage

// ----- hw/rtl/mwgh_if.sv -----
interface mwgh_in_if import mwgh_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mwgh_out_if import mwgh_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/mwgh_ram.sv -----
module mwgh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/mwgh_mac.sv -----
module mwgh_mac import mwgh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             op_valid,
	input  logic [31:0]      gi,
	input  logic [31:0]      gj,
	input  logic [31:0]      q,
	output logic [ACC_W-1:0] acc
);
	logic signed [63:0] p_s1;
	logic signed [31:0] q_s1;
	logic               v_s1;
	logic               clr_s1;
	logic signed [95:0] lo_s2;
	logic signed [95:0] hi_s2;
	logic               v_s2;
	logic               clr_s2;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   prod;
	logic [ACC_W-1:0]   base;

	// p = gi*gj, then p*q split into two 32x32 products to keep multipliers small
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			clr_s1 <= 1'b0;
			clr_s2 <= 1'b0;
		end else begin
			v_s1   <= op_valid;
			v_s2   <= v_s1;
			clr_s1 <= start;
			clr_s2 <= clr_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= $signed(gi) * $signed(gj);
		q_s1  <= $signed(q);
		lo_s2 <= $signed({1'b0, p_s1[31:0]}) * q_s1;
		hi_s2 <= $signed(p_s1[63:32]) * q_s1;
	end

	assign prod = ACC_W'($signed(lo_s2)) + (ACC_W'($signed(hi_s2)) << 32);
	assign base = clr_s2 ? '0 : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= base + prod;
		end else if (clr_s2) begin
			acc_q <= '0;
		end
	end

	assign acc = acc_q;
endmodule

// ----- hw/rtl/mpc_weighted_gram_hessian_top.sv -----
// Load items: accepted back to back while idle with no result pending.
// Compute row: reduce the row index modulo num_inputs by repeated subtraction, then per
// column read rows entries, drain the MAC pipeline, emit one result and advance.
// Out-of-range row: one result the cycle after the transfer. Input holds off until
// the last result of an item transfers; a stalled output holds the walk.
// Reset clears configuration to 1 and the controller to idle; memories stay undefined.
module mpc_weighted_gram_hessian_top import mwgh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	mwgh_in_if.sink     in_ch,
	mwgh_out_if.source  out_ch
);
	`include "mpc_weighted_gram_hessian_top_assert.svh"

	typedef enum logic [2:0] {ST_IDLE, ST_MOD, ST_READ, ST_DRAIN, ST_FIN, ST_OUT} state_t;

	cfg_t         cfg_q;
	state_t       state_q;
	logic [5:0]   row_q;
	logic [5:0]   col_q;
	logic [ROW_W:0] k_q;
	logic [OUT_W-1:0] kq_q;
	logic [2:0]   drain_q;
	logic         first_q;
	logic [8:0]   rows_q;
	logic [6:0]   cols_q;
	logic [INP_W-1:0] rsel_q;
	logic [5:0]   rem_q;
	logic         ovalid_q;
	out_item_t    odata_q;

	logic [3:0]   ny, nu;
	logic [5:0]   ph;
	logic [3:0]   ch;
	logic [8:0]   rows_w;
	logic [6:0]   cols_w;
	logic         acc_in;
	in_item_t     it;
	logic         g_we, q_we, r_we;
	logic [GADR_W-1:0] ai, aj;
	logic [31:0]  gi, gj, qv, rv;
	logic         mac_v, mac_start;
	logic [ACC_W-1:0] acc;
	logic [ACC_W-1:0] acc_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{4'd1, 4'd1, 6'd1, 4'd1};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_NUM_OUTPUTS:  cfg_q.num_outputs  <= cfg_data[3:0];
				REG_NUM_INPUTS:   cfg_q.num_inputs   <= cfg_data[3:0];
				REG_PRED_HORIZON: cfg_q.pred_horizon <= cfg_data;
				REG_CTRL_HORIZON: cfg_q.ctrl_horizon <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ny = (cfg_q.num_outputs == 4'd0) ? 4'd1 :
			(cfg_q.num_outputs > 4'd8 ? 4'd8 : cfg_q.num_outputs);
		nu = (cfg_q.num_inputs == 4'd0) ? 4'd1 :
			(cfg_q.num_inputs > 4'd8 ? 4'd8 : cfg_q.num_inputs);
		ph = (cfg_q.pred_horizon == 6'd0) ? 6'd1 :
			(cfg_q.pred_horizon > 6'd32 ? 6'd32 : cfg_q.pred_horizon);
		ch = (cfg_q.ctrl_horizon == 4'd0) ? 4'd1 :
			(cfg_q.ctrl_horizon > 4'd8 ? 4'd8 : cfg_q.ctrl_horizon);
		rows_w = {5'd0, ny} * {3'd0, ph};
		cols_w = {3'd0, nu} * {3'd0, ch};
	end

	assign it = in_ch.data;
	assign in_ch.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign acc_in = in_ch.valid && in_ch.ready;
	assign g_we = acc_in && it.func == FUNC_LOAD_G;
	assign q_we = acc_in && it.func == FUNC_LOAD_Q && it.row_index < 8'(MAX_OUTPUTS);
	assign r_we = acc_in && it.func == FUNC_LOAD_R && it.row_index < 8'(MAX_INPUTS);

	assign ai = {k_q[ROW_W-1:0], row_q};
	assign aj = {k_q[ROW_W-1:0], col_q};

	mwgh_ram #(.WIDTH(32), .DEPTH(MAX_ROWS*MAX_COLS)) u_gi (
		.clk, .we(g_we), .waddr({it.row_index, it.col_index}), .wdata(it.load_value),
		.raddr(ai), .rdata(gi));
	mwgh_ram #(.WIDTH(32), .DEPTH(MAX_ROWS*MAX_COLS)) u_gj (
		.clk, .we(g_we), .waddr({it.row_index, it.col_index}), .wdata(it.load_value),
		.raddr(aj), .rdata(gj));
	mwgh_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_q (
		.clk, .we(q_we), .waddr(it.row_index[OUT_W-1:0]), .wdata(it.load_value),
		.raddr(kq_q), .rdata(qv));
	mwgh_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS)) u_r (
		.clk, .we(r_we), .waddr(it.row_index[INP_W-1:0]), .wdata(it.load_value),
		.raddr(rsel_q), .rdata(rv));

	assign mac_start = (state_q == ST_READ) && first_q;
	logic mac_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mac_v_q <= 1'b0;
		else mac_v_q <= (state_q == ST_READ);
	end
	assign mac_v = mac_v_q;

	logic start_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= 1'b0;
		else start_q <= mac_start;
	end

	mwgh_mac u_mac (
		.clk, .arst_n, .start(start_q), .op_valid(mac_v),
		.gi, .gj, .q(qv), .acc);

	assign acc_r = acc + ((row_q == col_q) ? {{64{rv[31]}}, rv, 32'd0} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			row_q <= '0; col_q <= '0; k_q <= '0; kq_q <= '0;
			drain_q <= '0; first_q <= 1'b0; rows_q <= '0; cols_q <= '0; rsel_q <= '0;
			rem_q <= '0;
			odata_q <= '0;
		end else begin
			if (ovalid_q && out_ch.ready && state_q != ST_FIN) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in && it.func == FUNC_ROW) begin
						if ({1'b0, it.row_index} >= {2'b0, cols_w}) begin
							ovalid_q <= 1'b1;
							odata_q  <= '{it.row_index[5:0], 6'd0, 64'd0, 1'b1, 1'b1};
						end else begin
							row_q   <= it.row_index[5:0];
							col_q   <= '0;
							k_q     <= '0;
							kq_q    <= '0;
							first_q <= 1'b1;
							rows_q  <= rows_w;
							cols_q  <= cols_w;
							rem_q   <= it.row_index[5:0];
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (rem_q >= {2'b0, nu}) begin
						rem_q <= rem_q - {2'b0, nu};
					end else begin
						rsel_q  <= rem_q[INP_W-1:0];
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					first_q <= 1'b0;
					if (9'(k_q) + 9'd1 == rows_q) begin
						state_q <= ST_DRAIN;
						drain_q <= 3'd4;
					end else begin
						k_q  <= k_q + 1'b1;
						kq_q <= ({1'b0, kq_q} + 4'd1 == ny) ? '0 : kq_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (drain_q == 3'd0) state_q <= ST_FIN;
					else drain_q <= drain_q - 3'd1;
				end
				ST_FIN: begin
					if (!ovalid_q || out_ch.ready) begin
						ovalid_q <= 1'b1;
						odata_q  <= '{row_q, col_q, round_sat(acc_r), 1'b0,
							7'(col_q) + 7'd1 == cols_q};
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (7'(col_q) + 7'd1 == cols_q) begin
						state_q <= ST_IDLE;
					end else begin
						col_q   <= col_q + 6'd1;
						k_q     <= '0;
						kq_q    <= '0;
						first_q <= 1'b1;
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = odata_q;

	`MWGH_ASSERT_IMP(a_no_accept_busy, state_q != ST_IDLE, !in_ch.ready)
	`MWGH_ASSERT_IMP(a_col_in_range, state_q == ST_READ, 7'(col_q) < cols_q)
	`MWGH_ASSERT_NXT(a_fin_emits, state_q == ST_FIN && (!ovalid_q || out_ch.ready),
		out_ch.valid)
endmodule
